@@ src/wsp_pkg.sv @@
// Package: constants, types and helpers for the window stack and pointer handler.
package wsp_pkg;

  localparam int MAX_WINDOWS = 8;
  localparam int SLOT_W      = $clog2(MAX_WINDOWS);
  localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
  localparam int COORD_W     = 14;
  localparam int SIZE_W      = 13;
  localparam int AW          = 18;

  localparam int BOX_SIZE   = 18;
  localparam int BOX_INSET  = 5;
  localparam int GRIP       = 16;
  localparam int DRAG_KEEP  = 60;
  localparam int BTN_GAP    = 4;
  localparam int SIZE_MAX   = 8191;

  localparam int F_VALID = 0;
  localparam int F_MIN   = 1;
  localparam int F_RES   = 2;

  typedef enum logic [1:0] {
    CMD_MOUSE  = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_FOCUS  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_CREATED     = 4'd1,
    ACT_FULL        = 4'd2,
    ACT_CLOSED      = 4'd3,
    ACT_FOCUSED     = 4'd4,
    ACT_CLOSE_REQ   = 4'd5,
    ACT_MINIMIZED   = 4'd6,
    ACT_DRAG_START  = 4'd7,
    ACT_DRAGGED     = 4'd8,
    ACT_RESIZE_START= 4'd9,
    ACT_RESIZE_HELD = 4'd10,
    ACT_PRESS       = 4'd11,
    ACT_RELEASE     = 4'd12,
    ACT_HOVER       = 4'd13,
    ACT_BAD_SLOT    = 4'd14
  } action_t;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_TITLE_H  = 3'd2,
    REG_MIN_W    = 3'd3,
    REG_MIN_H    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOVE,
    S_HT_RD,
    S_HT_CK,
    S_PRESS,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
  } rect_t;

  function automatic logic signed [AW-1:0] sext(input logic [COORD_W-1:0] v);
    sext = AW'(signed'(v));
  endfunction

  function automatic logic signed [AW-1:0] zext(input logic [SIZE_W-1:0] v);
    zext = AW'(signed'({1'b0, v}));
  endfunction

  function automatic logic [14:0] sat15(input logic signed [AW-1:0] v);
    if (v < -AW'(16384)) sat15 = 15'h4000;
    else if (v > AW'(16383)) sat15 = 15'h3FFF;
    else sat15 = v[14:0];
  endfunction

endpackage

@@ src/window_stack_pointer_handler.sv @@
// Top level: window z-order table, hit testing, drag and resize sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  command  | start / busy           | command, buttons, pointer_x/y, slot, new_*
//  result   | done (one-cycle pulse) | action, window_*, content_*, consumed, ...
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A transaction runs from S_DISPATCH to S_EMIT_RD and S_EMIT; a held drag or
// resize passes through S_MOVE, and a hit test walks S_HT_RD for each window and
// S_HT_CK for each visible one, then S_PRESS on a press. A non-mouse command or
// a release goes straight to S_EMIT_RD. The rectangle RAM read port sets the
// pace. Reset clears the table and all drag/resize state. The result cannot be
// stalled; cfg_ready is always high.
module window_stack_pointer_handler
  import wsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [2:0]                buttons,
  input  logic signed [13:0]        pointer_x,
  input  logic signed [13:0]        pointer_y,
  input  logic [2:0]                slot,
  input  logic signed [13:0]        new_x,
  input  logic signed [13:0]        new_y,
  input  logic [12:0]               new_w,
  input  logic [12:0]               new_h,
  input  logic                      new_resizable,
  output logic                      done,
  output logic [3:0]                action,
  output logic [2:0]                window_slot,
  output logic signed [13:0]        window_left,
  output logic signed [13:0]        window_top,
  output logic [12:0]               window_width,
  output logic [12:0]               window_height,
  output logic signed [14:0]        content_x,
  output logic signed [14:0]        content_y,
  output logic                      consumed,
  output logic [2:0]                focused_slot,
  output logic                      focused_valid,
  output logic [3:0]                window_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [12:0]               cfg_data
);

  state_t state, state_next;

  logic [1:0]          cmd_q;
  logic [2:0]          btn_q;
  logic [COORD_W-1:0]  px_q, py_q, nx_q, ny_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SIZE_W-1:0]   nw_q, nh_q;
  logic                nres_q;

  logic [12:0] screen_w, screen_h;
  logic [6:0]  title_h;
  logic [10:0] min_w, min_h;

  logic [2:0]          last_buttons;
  logic                drag_active, resize_active, move_drag, is_press;
  logic [SLOT_W-1:0]   drag_target, resize_target;
  logic [14:0]         drag_off_x, drag_off_y;

  logic [2:0]          flags [MAX_WINDOWS];
  logic [SLOT_W-1:0]   order [MAX_WINDOWS];
  logic [CNT_W-1:0]    stack_count;
  logic [CNT_W-1:0]    remain;
  logic [SLOT_W-1:0]   hit_slot;
  rect_t               hit_rect;

  logic [3:0]          out_action;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_win, out_content, out_consumed;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  rect_t               ram_wdata, rd;

  wsp_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_WINDOWS)) u_rect_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // ---- searches over the small tables ----
  logic [SLOT_W-1:0] top_slot, free_slot, slot_pos, walk_slot, pos_sel;
  logic              top_valid, free_found, slot_found;
  logic [SLOT_W-1:0] order_rm [MAX_WINDOWS];
  logic [SLOT_W-1:0] order_up [MAX_WINDOWS];
  logic [SLOT_W-1:0] last_pos, raise_slot;
  logic [CNT_W-1:0]  remain_m1, count_m1;

  assign remain_m1 = remain - CNT_W'(1);
  assign count_m1  = stack_count - CNT_W'(1);
  assign walk_slot = order[remain_m1[SLOT_W-1:0]];
  assign last_pos  = count_m1[SLOT_W-1:0];

  always_comb begin
    top_slot   = '0;
    top_valid  = 1'b0;
    free_slot  = '0;
    free_found = 1'b0;
    slot_pos   = '0;
    slot_found = 1'b0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (CNT_W'(i) < stack_count && !flags[order[i]][F_MIN]) begin
        top_slot  = order[i];
        top_valid = 1'b1;
      end
      if (!free_found && !flags[i][F_VALID]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
      if (!slot_found && CNT_W'(i) < stack_count && order[i] == slot_q) begin
        slot_pos   = SLOT_W'(i);
        slot_found = 1'b1;
      end
    end
  end

  assign pos_sel    = (state == S_PRESS) ? remain_m1[SLOT_W-1:0] : slot_pos;
  assign raise_slot = (state == S_PRESS) ? hit_slot : slot_q;

  always_comb begin
    for (int k = 0; k < MAX_WINDOWS; k++) begin
      if (SLOT_W'(k) >= pos_sel && k + 1 < MAX_WINDOWS) begin
        order_rm[k] = order[(k + 1) % MAX_WINDOWS];
      end else begin
        order_rm[k] = order[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WINDOWS; k++) begin
      if (SLOT_W'(k) == last_pos) begin
        order_up[k] = raise_slot;
      end else begin
        order_up[k] = order_rm[k];
      end
    end
  end

  // ---- command decode ----
  logic left_btn, pressed, released, full, bad_slot, drag_go, res_go;
  assign left_btn = btn_q[0];
  assign pressed  = left_btn && !last_buttons[0];
  assign released = !left_btn && last_buttons[0];
  assign full     = !free_found || stack_count >= CNT_W'(MAX_WINDOWS);
  assign bad_slot = (32'(slot_q) >= MAX_WINDOWS) || !flags[slot_q][F_VALID];
  assign drag_go  = drag_active && left_btn;
  assign res_go   = !drag_go && resize_active && left_btn;

  // ---- arithmetic ----
  logic signed [AW-1:0] mx, my, rl, rt, rw, rh, th;
  logic signed [AW-1:0] sw, sh, mnw, mnh;
  assign mx  = sext(px_q);
  assign my  = sext(py_q);
  assign rl  = sext(rd.left);
  assign rt  = sext(rd.top);
  assign rw  = zext(rd.width);
  assign rh  = zext(rd.height);
  assign th  = AW'(title_h);
  assign sw  = zext(screen_w);
  assign sh  = zext(screen_h);
  assign mnw = AW'(signed'({1'b0, min_w}));
  assign mnh = AW'(signed'({1'b0, min_h}));

  logic signed [AW-1:0] dx, dy, nwv, nhv;
  always_comb begin
    dx = mx - AW'(signed'(drag_off_x));
    dy = my - AW'(signed'(drag_off_y));
    if (dy < 0) dy = '0;
    if (dx < AW'(DRAG_KEEP) - rw) dx = AW'(DRAG_KEEP) - rw;
    if (dx > sw - AW'(DRAG_KEEP)) dx = sw - AW'(DRAG_KEEP);
    if (dy > sh - th) dy = sh - th;
    nwv = mx - rl;
    nhv = my - rt;
    if (nwv < mnw) nwv = mnw;
    if (nhv < mnh) nhv = mnh;
    if (nwv > AW'(SIZE_MAX)) nwv = AW'(SIZE_MAX);
    if (nhv > AW'(SIZE_MAX)) nhv = AW'(SIZE_MAX);
  end

  logic hit;
  assign hit = mx >= rl && mx < rl + rw && my >= rt && my < rt + rh;

  // press classification on the saved rectangle
  logic signed [AW-1:0] hx, hy, hw, hh, bx, by, nb;
  logic in_title, on_close, on_min, on_grip;
  always_comb begin
    hx = sext(hit_rect.left);
    hy = sext(hit_rect.top);
    hw = zext(hit_rect.width);
    hh = zext(hit_rect.height);
    bx = hx + hw - AW'(BOX_SIZE + BOX_INSET);
    by = hy + AW'(BOX_INSET);
    nb = bx - AW'(BOX_SIZE + BTN_GAP);
    in_title = my >= hy && my < hy + th;
    on_close = mx >= bx && mx < bx + AW'(BOX_SIZE) && my >= by && my < by + AW'(BOX_SIZE);
    on_min   = mx >= nb && mx < nb + AW'(BOX_SIZE) && my >= by && my < by + AW'(BOX_SIZE);
    on_grip  = flags[hit_slot][F_RES] && mx >= hx + hw - AW'(GRIP)
               && my >= hy + hh - AW'(GRIP);
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (cmd_q != CMD_MOUSE) state_next = S_EMIT_RD;
        else if (drag_go || res_go) state_next = S_MOVE;
        else if (released) state_next = S_EMIT_RD;
        else state_next = S_HT_RD;
      end
      S_MOVE:     state_next = S_EMIT_RD;
      S_HT_RD: begin
        if (remain == '0) state_next = S_EMIT_RD;
        else if (!flags[walk_slot][F_MIN]) state_next = S_HT_CK;
      end
      S_HT_CK: begin
        if (!hit) state_next = S_HT_RD;
        else if (is_press) state_next = S_PRESS;
        else state_next = S_EMIT_RD;
      end
      S_PRESS:    state_next = S_EMIT_RD;
      S_EMIT_RD:  state_next = S_EMIT;
      S_EMIT:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // ---- RAM and port outputs ----
  logic signed [AW-1:0] ecx, ecy;
  assign ecx = mx - rl;
  assign ecy = my - (rt + th);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_slot;
    ram_wdata = '{left: nx_q, top: ny_q, width: nw_q, height: nh_q};
    ram_raddr = out_slot;
    case (state)
      S_DISPATCH: begin
        ram_raddr = drag_active ? drag_target : resize_target;
        ram_we    = (cmd_q == CMD_CREATE) && !full;
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = move_drag ? drag_target : resize_target;
        if (move_drag) begin
          ram_wdata = '{left: dx[COORD_W-1:0], top: dy[COORD_W-1:0],
                        width: rd.width, height: rd.height};
        end else begin
          ram_wdata = '{left: rd.left, top: rd.top,
                        width: nwv[SIZE_W-1:0], height: nhv[SIZE_W-1:0]};
        end
      end
      S_HT_RD:   ram_raddr = walk_slot;
      default:   ram_raddr = out_slot;
    endcase
  end

  assign busy      = state != S_IDLE;
  assign done      = state == S_EMIT;
  assign cfg_ready = 1'b1;

  always_comb begin
    action        = out_action;
    window_slot   = out_win ? out_slot : '0;
    window_left   = out_win ? rd.left : '0;
    window_top    = out_win ? rd.top : '0;
    window_width  = out_win ? rd.width : '0;
    window_height = out_win ? rd.height : '0;
    content_x     = out_content ? sat15(ecx) : '0;
    content_y     = out_content ? sat15(ecy) : '0;
    consumed      = out_consumed;
    focused_slot  = top_valid ? top_slot : '0;
    focused_valid = top_valid;
    window_count  = stack_count;
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= 13'd1024;
      screen_h <= 13'd768;
      title_h  <= 7'd24;
      min_w    <= 11'd120;
      min_h    <= 11'd80;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_W: screen_w <= cfg_data;
        REG_SCREEN_H: screen_h <= cfg_data;
        REG_TITLE_H:  title_h  <= cfg_data[6:0];
        REG_MIN_W:    min_w    <= cfg_data[10:0];
        REG_MIN_H:    min_h    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q  <= command;
      btn_q  <= buttons;
      px_q   <= pointer_x;
      py_q   <= pointer_y;
      slot_q <= slot;
      nx_q   <= new_x;
      ny_q   <= new_y;
      nw_q   <= new_w;
      nh_q   <= new_h;
      nres_q <= new_resizable;
    end
    if (state == S_HT_CK) begin
      hit_rect <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      last_buttons  <= '0;
      drag_active   <= 1'b0;
      drag_target   <= '0;
      drag_off_x    <= '0;
      drag_off_y    <= '0;
      resize_active <= 1'b0;
      resize_target <= '0;
      move_drag     <= 1'b0;
      is_press      <= 1'b0;
      remain        <= '0;
      hit_slot      <= '0;
      out_action    <= ACT_NONE;
      out_slot      <= '0;
      out_win       <= 1'b0;
      out_content   <= 1'b0;
      out_consumed  <= 1'b0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        flags[i] <= '0;
        order[i] <= '0;
      end
    end else begin
      case (state)
        S_DISPATCH: begin
          out_win      <= 1'b0;
          out_content  <= 1'b0;
          out_consumed <= 1'b0;
          out_action   <= ACT_NONE;
          case (cmd_q)
            CMD_CREATE: begin
              if (full) begin
                out_action <= ACT_FULL;
              end else begin
                flags[free_slot]            <= {nres_q, 1'b0, 1'b1};
                order[stack_count[SLOT_W-1:0]] <= free_slot;
                stack_count                 <= stack_count + CNT_W'(1);
                out_action                  <= ACT_CREATED;
                out_slot                    <= free_slot;
                out_win                     <= 1'b1;
              end
            end
            CMD_CLOSE, CMD_FOCUS: begin
              if (bad_slot) begin
                out_action <= ACT_BAD_SLOT;
              end else if (cmd_q == CMD_CLOSE) begin
                for (int k = 0; k < MAX_WINDOWS; k++) order[k] <= order_rm[k];
                stack_count    <= count_m1;
                flags[slot_q]  <= '0;
                if (drag_active && drag_target == slot_q) drag_active <= 1'b0;
                if (resize_active && resize_target == slot_q) resize_active <= 1'b0;
                out_action     <= ACT_CLOSED;
                out_slot       <= slot_q;
                out_win        <= 1'b1;
              end else begin
                for (int k = 0; k < MAX_WINDOWS; k++) order[k] <= order_up[k];
                flags[slot_q][F_MIN]  <= 1'b0;
                out_action            <= ACT_FOCUSED;
                out_slot              <= slot_q;
                out_win               <= 1'b1;
              end
            end
            default: begin
              last_buttons <= btn_q;
              is_press     <= pressed;
              remain       <= stack_count;
              move_drag    <= drag_go;
              if (drag_active && !left_btn) drag_active <= 1'b0;
              if (resize_active && !left_btn) resize_active <= 1'b0;
              if (drag_go || res_go) begin
                out_action   <= drag_go ? ACT_DRAGGED : ACT_RESIZE_HELD;
                out_slot     <= drag_go ? drag_target : resize_target;
                out_win      <= 1'b1;
                out_consumed <= 1'b1;
              end else if (released && top_valid) begin
                out_action  <= ACT_RELEASE;
                out_slot    <= top_slot;
                out_win     <= 1'b1;
                out_content <= 1'b1;
              end
            end
          endcase
        end
        S_HT_RD: begin
          if (remain != '0) begin
            hit_slot <= walk_slot;
            if (flags[walk_slot][F_MIN]) remain <= remain_m1;
          end
        end
        S_HT_CK: begin
          if (!hit) begin
            remain <= remain_m1;
          end else if (!is_press) begin
            out_consumed <= 1'b1;
            if (my >= rt + th) begin
              out_action  <= ACT_HOVER;
              out_slot    <= hit_slot;
              out_win     <= 1'b1;
              out_content <= 1'b1;
            end
          end
        end
        S_PRESS: begin
          for (int k = 0; k < MAX_WINDOWS; k++) order[k] <= order_up[k];
          flags[hit_slot][F_MIN]  <= in_title && !on_close && on_min;
          out_slot                <= hit_slot;
          out_win                 <= 1'b1;
          out_consumed            <= 1'b1;
          if (in_title) begin
            if (on_close) begin
              out_action <= ACT_CLOSE_REQ;
            end else if (on_min) begin
              out_action             <= ACT_MINIMIZED;
            end else begin
              drag_active <= 1'b1;
              drag_target <= hit_slot;
              drag_off_x  <= 15'(mx - hx);
              drag_off_y  <= 15'(my - hy);
              out_action  <= ACT_DRAG_START;
            end
          end else if (on_grip) begin
            resize_active <= 1'b1;
            resize_target <= hit_slot;
            out_action    <= ACT_RESIZE_START;
          end else begin
            out_action  <= ACT_PRESS;
            out_content <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_shot: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(drag_active && resize_active))
    else $error("drag and resize active together");
  a_count: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_W'(MAX_WINDOWS))
    else $error("window count above table size");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");
`endif

endmodule

@@ src/wsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
